### src/lpbi_pkg.sv
// Package: shared types and codes for the linear-probe blob index.
package lpbi_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_PROBE_REQ,
        S_PROBE_CHK,
        S_WRITE,
        S_CLEAR,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic div_start;
        logic probe_init; // set index/count from home
        logic rd;         // issue memory read at probe index
        logic advance;    // step probe index
        logic wr;         // write entry at probe index
        logic clr_start;
        logic res_ok_ins;
        logic res_found;
        logic res_miss;
        logic res_full;
        logic res_zero;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic    size_zero;
        logic    div_done;
        logic    free_hit;   // probed slot unused (insert)
        logic    key_hit;    // probed slot used and key matches (lookup)
        logic    probe_last; // all slots probed
        logic    clr_done;
        t_action action;
    } t_sts;

endpackage

### src/lpbi_ctrl.sv
// Controller: sequences divide, probe, write and clear steps.
module lpbi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_go,
    input  logic           i_out_free,
    input  lpbi_pkg::t_sts i_sts,
    output lpbi_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    lpbi_pkg::t_state r_state, n_state;
    // clear after reset produces no result
    logic             r_rst_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpbi_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rst_clr <= 1'b1;
        else if (r_state == lpbi_pkg::S_CLEAR && i_sts.clr_done) r_rst_clr <= 1'b0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpbi_pkg::S_IDLE: begin
                if (i_in_go) n_state = lpbi_pkg::S_DIV;
            end
            lpbi_pkg::S_DIV: begin
                if (i_sts.action == lpbi_pkg::ACT_CLEAR) n_state = lpbi_pkg::S_CLEAR;
                else if (i_sts.action == lpbi_pkg::ACT_NOP || i_sts.size_zero)
                    n_state = lpbi_pkg::S_OUT;
                else n_state = lpbi_pkg::S_CHECK;
            end
            lpbi_pkg::S_CHECK: begin
                if (i_sts.div_done) n_state = lpbi_pkg::S_PROBE_REQ;
            end
            lpbi_pkg::S_PROBE_REQ: n_state = lpbi_pkg::S_PROBE_CHK;
            lpbi_pkg::S_PROBE_CHK: begin
                if (i_sts.action == lpbi_pkg::ACT_INSERT && i_sts.free_hit)
                    n_state = lpbi_pkg::S_WRITE;
                else if (i_sts.action == lpbi_pkg::ACT_LOOKUP && i_sts.key_hit)
                    n_state = lpbi_pkg::S_OUT;
                else if (i_sts.probe_last) n_state = lpbi_pkg::S_OUT;
                else n_state = lpbi_pkg::S_PROBE_REQ;
            end
            lpbi_pkg::S_WRITE: n_state = lpbi_pkg::S_OUT;
            lpbi_pkg::S_CLEAR: begin
                if (i_sts.clr_done) n_state = (i_sts.action == lpbi_pkg::ACT_CLEAR &&
                    !r_rst_clr) ? lpbi_pkg::S_OUT : lpbi_pkg::S_IDLE;
            end
            lpbi_pkg::S_OUT: begin
                if (i_out_free) n_state = lpbi_pkg::S_IDLE;
            end
            default: n_state = lpbi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            lpbi_pkg::S_IDLE: begin
                o_cmd.load = i_in_go;
            end
            lpbi_pkg::S_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.clr_start = (i_sts.action == lpbi_pkg::ACT_CLEAR);
                o_cmd.res_zero  = (i_sts.action == lpbi_pkg::ACT_CLEAR) ||
                                  (i_sts.action == lpbi_pkg::ACT_NOP);
                o_cmd.res_full  = i_sts.size_zero && (i_sts.action == lpbi_pkg::ACT_INSERT);
                o_cmd.res_miss  = i_sts.size_zero && (i_sts.action == lpbi_pkg::ACT_LOOKUP);
            end
            lpbi_pkg::S_CHECK: begin
                o_cmd.probe_init = i_sts.div_done;
            end
            lpbi_pkg::S_PROBE_REQ: o_cmd.rd = 1'b1;
            lpbi_pkg::S_PROBE_CHK: begin
                if (i_sts.action == lpbi_pkg::ACT_INSERT && i_sts.free_hit) begin
                    o_cmd.res_ok_ins = 1'b1;
                end else if (i_sts.action == lpbi_pkg::ACT_LOOKUP && i_sts.key_hit) begin
                    o_cmd.res_found = 1'b1;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_full = (i_sts.action == lpbi_pkg::ACT_INSERT);
                    o_cmd.res_miss = (i_sts.action == lpbi_pkg::ACT_LOOKUP);
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            lpbi_pkg::S_WRITE: o_cmd.wr = 1'b1;
            lpbi_pkg::S_CLEAR: o_cmd = '0;
            lpbi_pkg::S_OUT: o_cmd.out_load = i_out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != lpbi_pkg::S_IDLE);

endmodule

### src/lpbi_div.sv
// Divider: 64-bit key modulo table size, one quotient bit per cycle.
module lpbi_div #(
    parameter int IdxW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_dividend,
    input  logic [IdxW:0] i_divisor,
    output logic          o_done,
    output logic [IdxW:0] o_rem
);

    logic [63:0]   r_num;
    logic [IdxW:0] r_rem;
    logic [6:0]    r_cnt;
    logic          r_run;
    logic [IdxW+1:0] w_sh;

    assign w_sh = {r_rem, r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= 7'd64;
        end else if (r_run) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_num <= {r_num[62:0], 1'b0};
            if (w_sh >= {1'b0, i_divisor}) r_rem <= (IdxW+1)'(w_sh - {1'b0, i_divisor});
            else r_rem <= w_sh[IdxW:0];
        end
    end

    assign o_done = !r_run && !i_start;
    assign o_rem  = r_rem;

endmodule

### src/lpbi_dp.sv
// Datapath: slot memories, used marks, probe index, result register.
module lpbi_dp #(
    parameter int TableDepth = 1024,
    parameter int IdxW       = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpbi_pkg::t_cmd      i_cmd,
    output lpbi_pkg::t_sts      o_sts,
    input  logic [10:0]         i_table_size,
    input  logic [1:0]          i_action,
    input  logic [63:0]         i_key,
    input  logic [31:0]         i_entry_offset,
    input  logic [31:0]         i_entry_length,
    output logic [1:0]          o_status,
    output logic [9:0]          o_slot,
    output logic [31:0]         o_found_offset,
    output logic [31:0]         o_found_length
);

    localparam int SzW = IdxW + 1;

    logic [63:0] mem_key [TableDepth];
    logic [31:0] mem_off [TableDepth];
    logic [31:0] mem_len [TableDepth];
    logic        mem_used [TableDepth];

    lpbi_pkg::t_action r_act;
    logic [63:0]   r_key;
    logic [31:0]   r_off, r_len;
    logic [SzW-1:0] r_n;
    logic [IdxW-1:0] r_idx;
    logic [SzW-1:0]  r_cnt;
    logic [IdxW-1:0] r_clr;
    logic            r_clr_run;
    logic [63:0]     r_rd_key;
    logic [31:0]     r_rd_off, r_rd_len;
    logic            r_rd_used;
    logic [1:0]      r_st;
    logic [IdxW-1:0] r_slot;
    logic [31:0]     r_fo, r_fl;
    logic [1:0]      r_ost;
    logic [9:0]      r_oslot;
    logic [31:0]     r_ofo, r_ofl;
    logic            w_div_done;
    logic [SzW-1:0]  w_rem;
    logic [SzW-1:0]  w_sz_sat;
    logic [SzW-1:0]  w_next;

    // saturate size to depth
    always_comb begin
        if (32'(i_table_size) > 32'(TableDepth))
            w_sz_sat = SzW'(TableDepth);
        else
            w_sz_sat = SzW'(i_table_size);
    end

    lpbi_div #(.IdxW(IdxW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(r_key),
        .i_divisor (r_n),
        .o_done    (w_div_done),
        .o_rem     (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= lpbi_pkg::t_action'(i_action);
            r_key <= i_key;
            r_off <= i_entry_offset;
            r_len <= i_entry_length;
            r_n   <= w_sz_sat;
        end
    end

    assign w_next = ({1'b0, r_idx} + SzW'(1) >= r_n) ? '0 : {1'b0, r_idx} + SzW'(1);

    // probe index: insert starts after home, lookup at home
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_cnt <= SzW'(1);
            if (r_act == lpbi_pkg::ACT_INSERT)
                r_idx <= (w_rem + SzW'(1) >= r_n) ? '0 : IdxW'(w_rem + SzW'(1));
            else
                r_idx <= IdxW'(w_rem);
        end else if (i_cmd.advance) begin
            r_cnt <= r_cnt + SzW'(1);
            r_idx <= IdxW'(w_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key <= mem_key[r_idx];
            r_rd_off <= mem_off[r_idx];
            r_rd_len <= mem_len[r_idx];
        end
        if (i_cmd.wr) begin
            mem_key[r_idx] <= r_key;
            mem_off[r_idx] <= r_off;
            mem_len[r_idx] <= r_len;
        end
    end

    // used marks, cleared by a sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd_used <= mem_used[r_idx];
        if (r_clr_run) mem_used[r_clr] <= 1'b0;
        else if (i_cmd.wr) mem_used[r_idx] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_run <= 1'b1;
            r_clr     <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_run <= 1'b1;
            r_clr     <= '0;
        end else if (r_clr_run) begin
            r_clr <= r_clr + IdxW'(1);
            if (r_clr == IdxW'(TableDepth - 1)) r_clr_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ok_ins) begin
            r_st <= lpbi_pkg::ST_OK; r_slot <= r_idx; r_fo <= '0; r_fl <= '0;
        end else if (i_cmd.res_found) begin
            r_st <= lpbi_pkg::ST_OK; r_slot <= r_idx; r_fo <= r_rd_off; r_fl <= r_rd_len;
        end else if (i_cmd.res_miss) begin
            r_st <= lpbi_pkg::ST_MISS; r_slot <= '0; r_fo <= '0; r_fl <= '0;
        end else if (i_cmd.res_full) begin
            r_st <= lpbi_pkg::ST_FULL; r_slot <= '0; r_fo <= '0; r_fl <= '0;
        end else if (i_cmd.res_zero) begin
            r_st <= lpbi_pkg::ST_OK; r_slot <= '0; r_fo <= '0; r_fl <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ost <= r_st; r_oslot <= 10'(r_slot); r_ofo <= r_fo; r_ofl <= r_fl;
        end
    end

    assign o_sts.size_zero  = (r_n == '0);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.free_hit   = !r_rd_used;
    assign o_sts.key_hit    = r_rd_used && (r_rd_key == r_key);
    assign o_sts.probe_last = (r_cnt >= r_n);
    assign o_sts.clr_done   = !r_clr_run;
    assign o_sts.action     = r_act;

    assign o_status       = r_ost;
    assign o_slot         = r_oslot;
    assign o_found_offset = r_ofo;
    assign o_found_length = r_ofl;

endmodule

### src/linear_probe_blob_index_core.sv
// Top level: linear-probing blob index with controller and datapath.
// Sequencing: a no-op or a size-zero item goes straight to the result, a clear first sweeps
//   all used marks, and insert/lookup run a bit-serial modulo of the key, then one memory read
//   and one compare per probed slot, with one write more when an insert stores.
// Throughput: one item at a time; the next transfer is taken once the controller is idle,
//   a held result does not block it. Reset runs a sweep that drops all used marks; no input
//   is taken during it, config still is.
module linear_probe_blob_index_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_entry_offset,
    input  logic [31:0] i_entry_length,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [31:0] o_found_offset,
    output logic [31:0] o_found_length,
    // table_size register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int IdxW = $clog2(TABLE_DEPTH);

    lpbi_pkg::t_cmd w_cmd;
    lpbi_pkg::t_sts w_sts;
    logic           w_busy;
    logic           w_in_go;
    logic           r_ovalid;
    logic [10:0]    r_table_size;

    // config is always writable; caller keeps it to idle periods
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_table_size <= '0;
        else if (i_cfg_valid) r_table_size <= i_cfg_data;
    end

    // one item in flight; the output register lets a new transfer start
    // while the previous result still waits, the controller holds in S_OUT
    assign o_stall = w_busy;
    assign w_in_go = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_cmd.out_load) r_ovalid <= 1'b1;
        else if (!i_stall) r_ovalid <= 1'b0;
    end
    assign o_valid = r_ovalid;

    lpbi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_go   (w_in_go),
        .i_out_free(!r_ovalid),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_busy    (w_busy)
    );

    lpbi_dp #(.TableDepth(TABLE_DEPTH), .IdxW(IdxW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_table_size  (r_table_size),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_entry_offset(i_entry_offset),
        .i_entry_length(i_entry_length),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_found_offset(o_found_offset),
        .o_found_length(o_found_length)
    );

endmodule

### src/lpbi_checker.sv
// Checker: port-level properties of the blob index, bound to the top level.
module lpbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [9:0]  o_slot,
    input logic [31:0] o_found_offset
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second input taken while an item is in flight");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != lpbi_pkg::ST_RSVD)
        else $error("reserved status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == lpbi_pkg::ST_MISS || o_status == lpbi_pkg::ST_FULL) |->
        o_slot == '0 && o_found_offset == '0)
        else $error("miss or full carries data");

endmodule

bind linear_probe_blob_index_core lpbi_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_slot        (o_slot),
    .o_found_offset(o_found_offset)
);

### tb/lpbi_scoreboard.sv
// Checker for the linear-probe blob index: watches all channels, predicts and compares.
`timescale 1ns / 1ps
module lpbi_scoreboard #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_entry_offset,
    input  logic [31:0] i_entry_length,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_status,
    input  logic [9:0]  o_slot,
    input  logic [31:0] o_found_offset,
    input  logic [31:0] o_found_length,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct {
        lpbi_pkg::t_status status;
        logic [9:0]        slot;
        logic [31:0]       offset;
        logic [31:0]       length;
    } t_result;

    logic [63:0] tbl_key [TABLE_DEPTH];
    logic [31:0] tbl_off [TABLE_DEPTH];
    logic [31:0] tbl_len [TABLE_DEPTH];
    bit          tbl_used [TABLE_DEPTH];
    logic [10:0] size_reg;
    t_result     expected_q [$];

    // one table operation; updates the shadow table
    function automatic t_result table_op(input lpbi_pkg::t_action act,
                                         input logic [63:0] key,
                                         input logic [31:0] off, input logic [31:0] len);
        t_result r;
        int n;
        int home;
        int idx;
        r = '{lpbi_pkg::ST_OK, '0, '0, '0};
        n = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
        if (act == lpbi_pkg::ACT_CLEAR) begin
            foreach (tbl_used[i]) tbl_used[i] = 0;
            return r;
        end
        if (act == lpbi_pkg::ACT_NOP) return r;
        if (n == 0) begin
            r.status = (act == lpbi_pkg::ACT_INSERT) ? lpbi_pkg::ST_FULL : lpbi_pkg::ST_MISS;
            return r;
        end
        home = int'(key % 64'(n));
        if (act == lpbi_pkg::ACT_INSERT) begin
            idx = home;
            for (int p = 0; p < n; p++) begin
                idx = (idx + 1) % n;
                if (!tbl_used[idx]) begin
                    tbl_used[idx] = 1;
                    tbl_key[idx] = key;
                    tbl_off[idx] = off;
                    tbl_len[idx] = len;
                    r.slot = 10'(idx);
                    return r;
                end
            end
            r.status = lpbi_pkg::ST_FULL;
            return r;
        end
        for (int p = 0; p < n; p++) begin
            idx = (home + p) % n;
            if (tbl_used[idx] && tbl_key[idx] == key) begin
                r.slot = 10'(idx);
                r.offset = tbl_off[idx];
                r.length = tbl_len[idx];
                return r;
            end
        end
        r.status = lpbi_pkg::ST_MISS;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            foreach (tbl_used[i]) tbl_used[i] = 0;
            size_reg = '0;
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) size_reg = i_cfg_data;
            // result side first so a same-edge input transfer is not matched
            if (o_valid && !i_stall) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result status %0d slot %0d", $realtime,
                                 o_status, o_slot);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_status !== exp_r.status || o_slot !== exp_r.slot ||
                        o_found_offset !== exp_r.offset || o_found_length !== exp_r.length)
                    begin
                        if (o_errors < 10)
                            $display({"%0t: mismatch exp st %0d slot %0d off %h len %h, ",
                                      "got st %0d slot %0d off %h len %h"},
                                     $realtime, exp_r.status, exp_r.slot, exp_r.offset,
                                     exp_r.length, o_status, o_slot, o_found_offset,
                                     o_found_length);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !o_stall)
                expected_q.push_back(table_op(lpbi_pkg::t_action'(i_action), i_key,
                                              i_entry_offset, i_entry_length));
        end
        o_pending <= expected_q.size();
    end

endmodule

### tb/linear_probe_blob_index_core_test.sv
// Testbench top: stimulus, idling, watchdog and verdict for the blob index core.
`timescale 1ns / 1ps
module linear_probe_blob_index_core_test;

    localparam int DEPTH = 1024;
    // the limit must cover a full probe of 1024 slots plus the modulo,
    // stretched by the receiver's stall, and the reset sweep
    localparam int IDLE_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [63:0] i_key;
    logic [31:0] i_entry_offset;
    logic [31:0] i_entry_length;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [9:0]  o_slot;
    logic [31:0] o_found_offset;
    logic [31:0] o_found_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;

    int errors;
    int pending;
    int results;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int cfg_writes;
    logic [63:0] key_pool [$];

    linear_probe_blob_index_core #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    lpbi_scoreboard #(.TABLE_DEPTH(DEPTH)) u_scoreboard (
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: stall at random per the current idling mode
    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // watchdog: cycles with no transfer on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         quiet, pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // one input transfer; returns at the falling edge after acceptance with
    // valid still high so a back-to-back item needs no second assignment
    task automatic send_item(input lpbi_pkg::t_action act, input logic [63:0] key,
                             input logic [31:0] off, input logic [31:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_key          <= key;
        i_entry_offset <= off;
        i_entry_length <= len;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (act == lpbi_pkg::ACT_INSERT && key_pool.size() < 64) key_pool.push_back(key);
    endtask

    // sender holds off until every expected result is back
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // table_size write, only with the block idle
    task automatic set_size(input logic [10:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        key_pool.delete();
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2, 3: return 64'($urandom_range(0, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // random item; lookups mostly hit keys already inserted
    task automatic random_item();
        int roll;
        logic [63:0] key;
        roll = $urandom_range(0, 99);
        key = pick_key();
        if (roll < 45) begin
            if (key_pool.size() != 0 && $urandom_range(0, 99) < 20)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item(lpbi_pkg::ACT_INSERT, key, pick_word(), pick_word());
        end else if (roll < 93) begin
            if (key_pool.size() != 0 && $urandom_range(0, 99) < 70)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item(lpbi_pkg::ACT_LOOKUP, key, pick_word(), pick_word());
        end else if (roll < 97) begin
            send_item(lpbi_pkg::ACT_CLEAR, key, pick_word(), pick_word());
            key_pool.delete();
        end else begin
            send_item(lpbi_pkg::ACT_NOP, key, pick_word(), pick_word());
        end
    endtask

    initial begin
        int sizes [10] = '{3, 1, 7, 16, 5, 2, 13, 1024, 2047, 0};
        int counts [10] = '{110, 60, 110, 120, 100, 60, 110, 12, 8, 20};
        int done_items;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = lpbi_pkg::ACT_NOP;
        i_key          = '0;
        i_entry_offset = '0;
        i_entry_length = '0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_idle_pct  = 26;
        recv_idle_pct  = 73;
        items_sent     = 0;
        cfg_writes     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size zero first, still at its reset value
        send_item(lpbi_pkg::ACT_INSERT, 64'd5, '1, '1);
        send_item(lpbi_pkg::ACT_LOOKUP, 64'd5, '0, '0);
        send_item(lpbi_pkg::ACT_NOP, '1, '1, '1);
        set_size(11'd4);
        // extreme fields, duplicates, hit and miss
        send_item(lpbi_pkg::ACT_INSERT, '1, '1, '1);
        send_item(lpbi_pkg::ACT_INSERT, '0, '0, '0);
        send_item(lpbi_pkg::ACT_INSERT, '1, 32'h1234_5678, 32'h9abc_def0);
        send_item(lpbi_pkg::ACT_LOOKUP, '1, '0, '0);
        send_item(lpbi_pkg::ACT_LOOKUP, '0, '1, '1);
        send_item(lpbi_pkg::ACT_LOOKUP, 64'd77, '0, '0);
        // fill the table, then an insert that finds it full
        send_item(lpbi_pkg::ACT_INSERT, 64'd6, 32'd1, 32'd2);
        send_item(lpbi_pkg::ACT_INSERT, 64'd9, 32'd3, 32'd4);
        send_item(lpbi_pkg::ACT_LOOKUP, 64'd6, '0, '0);
        send_item(lpbi_pkg::ACT_NOP, 64'd6, '1, '1);
        // shrink with entries present: upper slots go out of reach
        set_size(11'd2);
        send_item(lpbi_pkg::ACT_LOOKUP, '1, '0, '0);
        send_item(lpbi_pkg::ACT_LOOKUP, 64'd6, '0, '0);
        send_item(lpbi_pkg::ACT_INSERT, 64'd8, 32'd5, 32'd6);
        send_item(lpbi_pkg::ACT_CLEAR, '0, '0, '0);
        send_item(lpbi_pkg::ACT_LOOKUP, '0, '0, '0);
        // oversized size saturates to the full depth
        set_size(11'h7FF);
        send_item(lpbi_pkg::ACT_INSERT, '1, 32'hdead_beef, 32'h0bad_f00d);
        send_item(lpbi_pkg::ACT_INSERT, 64'd1023, '1, '0);
        send_item(lpbi_pkg::ACT_LOOKUP, '1, '0, '0);
        send_item(lpbi_pkg::ACT_LOOKUP, 64'd1023, '0, '0);

        // random phases, idling mode by progress through the item count
        done_items = 0;
        foreach (sizes[p]) begin
            set_size(11'(sizes[p]));
            for (int i = 0; i < counts[p]; i++) begin
                if (done_items < 270) begin
                    send_idle_pct = 26;
                    recv_idle_pct = 73;
                end else if (done_items < 540) begin
                    send_idle_pct = 73;
                    recv_idle_pct = 26;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_item();
                done_items++;
                if (i == counts[p] / 2) drain();
            end
        end

        drain();
        repeat (40) @(negedge i_clk);
        $display("Sent %0d items over %0d table_size writes (sizes 0 to 2047),",
                 items_sent, cfg_writes);
        $display("%0d results checked under stalls on both sides.", results);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### linear_probe_blob_index_core.f
src/lpbi_pkg.sv
src/lpbi_ctrl.sv
src/lpbi_div.sv
src/lpbi_dp.sv
src/linear_probe_blob_index_core.sv
src/lpbi_checker.sv
tb/lpbi_scoreboard.sv
tb/linear_probe_blob_index_core_test.sv
